/* sv/cala_pkg.sv */
// cala_pkg: shared types and constants of the calibrated altitude averager.
// Holds the request function codes, the controller command and status structs.
// No dependencies.
package cala_pkg;

    localparam int unsigned RANGE_W = 12;  // width of the height span register
    localparam int unsigned PCT_W   = 7;   // width of the altitude percentage
    localparam int unsigned MEAN_W  = 12;  // width of the reported mean level

    localparam logic [RANGE_W-1:0] RANGE_RESET  = 12'd1241;
    localparam logic [PCT_W-1:0]   FULL_PERCENT = 7'd100;
    localparam logic [PCT_W-1:0]   ZERO_PERCENT = 7'd0;

    // Register index as seen in paddr[2]
    localparam logic REG_SPAN = 1'b0;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_RECAL  = 2'd2
    } t_func;

    typedef struct packed {
        logic capture;     // latch the request payload
        logic smp_write;   // update the running sum, write the ring, advance the slot
        logic tick_count;  // count one conversion while uncalibrated
        logic mean_start;  // register the reciprocal product of the rounded mean
        logic mean_latch;  // take the mean, capture the reference if due
        logic pct_short;   // settle the percentage without a division
        logic pct_start;   // launch the divider on the percentage
        logic pct_latch;   // take the saturated percentage
        logic recal;       // clear the flag and the count
        logic load_out;    // load the result register
    } t_cmd;

    typedef struct packed {
        logic div_done;     // divider quotient is ready this cycle
        logic change_zero;  // reference does not lie above the mean
        logic range_zero;   // configured range is zero
    } t_status;

endpackage

/* sv/cala_div.sv */
// cala_div: restoring divider, one quotient bit per cycle.
// No dependencies.
module cala_div #(
    parameter int W = 19
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);

    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W:0]   w_trial;
    logic [W:0]   w_diff;
    logic         w_ge;

    assign w_trial = {r_rem, r_quo[W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* sv/cala_datapath.sv */
// cala_datapath: sample ring, running sum, calibration state and result register.
// Depends on cala_pkg and cala_div.
module cala_datapath #(
    parameter int RING_DEPTH  = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cala_pkg::t_cmd                 i_cmd,
    output cala_pkg::t_status              o_status,
    input  logic [SAMPLE_BITS-1:0]         i_sample,
    input  logic [cala_pkg::RANGE_W-1:0]   i_height_span,
    output logic [cala_pkg::PCT_W-1:0]     o_altitude_percent,
    output logic [cala_pkg::MEAN_W-1:0]    o_mean_level,
    output logic                           o_calibrated
);

    import cala_pkg::*;

    localparam int SB       = SAMPLE_BITS;
    localparam int SLOT_W   = $clog2(RING_DEPTH);
    localparam int SUM_W    = SB + $clog2(RING_DEPTH);
    localparam int CNT_W    = $clog2(RING_DEPTH + 2);
    localparam int MEAN_NW  = SUM_W + 1;
    localparam int MEAN_DEN = 2 * RING_DEPTH;
    // Rounded mean by reciprocal multiply: exact for every numerator below 2**MEAN_NW
    localparam int MEAN_SH  = MEAN_NW + $clog2(MEAN_DEN);
    localparam int RECIP_W  = MEAN_NW + 1;
    localparam int PROD_W   = MEAN_NW + RECIP_W;
    localparam longint unsigned MEAN_RECIP =
        ((64'd1 << MEAN_SH) + 64'(MEAN_DEN) - 64'd1) / 64'(MEAN_DEN);
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(MEAN_RECIP);
    localparam int PCT_NW   = SB + PCT_W;
    localparam int DIV_W    = PCT_NW;

    logic [SB-1:0]         r_sample;
    logic [SB-1:0]         r_ring [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_ring_vld;
    logic [SB-1:0]         r_rd_data;
    logic                  r_rd_vld;
    logic [SLOT_W-1:0]     r_slot;
    logic [SUM_W-1:0]      r_sum;
    logic [SB-1:0]         r_ref;
    logic                  r_cal;
    logic [CNT_W-1:0]      r_tick_cnt;
    logic [SB-1:0]         r_last_mean;
    logic [PCT_W-1:0]      r_last_pct;
    logic [PCT_W-1:0]      r_out_pct;
    logic [SB-1:0]         r_out_mean;
    logic                  r_out_cal;
    logic [PROD_W-1:0]     r_mean_prod;

    logic [SB-1:0]         w_old;
    logic [SB-1:0]         w_change;
    logic [PCT_NW-1:0]     w_pct_num;
    logic [MEAN_NW-1:0]    w_mean_num;
    logic [SB-1:0]         w_mean;
    logic [DIV_W-1:0]      w_quo;
    logic                  w_div_done;
    logic [SB+MEAN_W-1:0]  w_mean_ext;

    // Never-written ring entries read as zero
    assign w_old      = r_rd_vld ? r_rd_data : '0;
    assign w_change   = (r_ref > r_last_mean) ? (r_ref - r_last_mean) : '0;
    assign w_pct_num  = PCT_NW'(w_change) * PCT_NW'(FULL_PERCENT);
    assign w_mean_num = MEAN_NW'({r_sum, 1'b0}) + MEAN_NW'(RING_DEPTH);
    assign w_mean     = r_mean_prod[MEAN_SH +: SB];

    cala_div #(
        .W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.pct_start),
        .i_dividend (w_pct_num),
        .i_divisor  (DIV_W'(i_height_span)),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign o_status.div_done    = w_div_done;
    assign o_status.change_zero = (w_change == '0);
    assign o_status.range_zero  = (i_height_span == '0);

    // Ring memory: registered read at the current slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.smp_write) begin
            r_ring[r_slot] <= r_sample;
        end
        r_rd_data <= r_ring[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_sample;
        end
        if (i_cmd.mean_start) begin
            r_mean_prod <= PROD_W'(w_mean_num) * PROD_W'(RECIP_K);
        end
        if (i_cmd.load_out) begin
            r_out_pct  <= r_last_pct;
            r_out_mean <= r_last_mean;
            r_out_cal  <= r_cal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld  <= '0;
            r_rd_vld    <= 1'b0;
            r_slot      <= '0;
            r_sum       <= '0;
            r_ref       <= '0;
            r_cal       <= 1'b0;
            r_tick_cnt  <= '0;
            r_last_mean <= '0;
            r_last_pct  <= '0;
        end else begin
            r_rd_vld <= r_ring_vld[r_slot];
            if (i_cmd.smp_write) begin
                r_sum              <= r_sum - SUM_W'(w_old) + SUM_W'(r_sample);
                r_ring_vld[r_slot] <= 1'b1;
                r_slot             <= (r_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : r_slot + 1'b1;
            end
            if (i_cmd.tick_count && !r_cal && (r_tick_cnt <= CNT_W'(RING_DEPTH))) begin
                r_tick_cnt <= r_tick_cnt + 1'b1;
            end
            if (i_cmd.mean_latch) begin
                r_last_mean <= w_mean;
                if (!r_cal && (r_tick_cnt > CNT_W'(RING_DEPTH))) begin
                    r_ref <= w_mean;
                    r_cal <= 1'b1;
                end
            end
            if (i_cmd.pct_short) begin
                r_last_pct <= (w_change == '0) ? ZERO_PERCENT : FULL_PERCENT;
            end
            if (i_cmd.pct_latch) begin
                r_last_pct <= (w_quo > DIV_W'(FULL_PERCENT)) ? FULL_PERCENT : w_quo[PCT_W-1:0];
            end
            if (i_cmd.recal) begin
                r_cal      <= 1'b0;
                r_tick_cnt <= '0;
            end
        end
    end

    assign w_mean_ext         = {{MEAN_W{1'b0}}, r_out_mean};
    assign o_altitude_percent = r_out_pct;
    assign o_mean_level       = w_mean_ext[MEAN_W-1:0];
    assign o_calibrated       = r_out_cal;

    a_cal_needs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_cal) |-> (r_tick_cnt == CNT_W'(RING_DEPTH + 1)))
        else $error("calibration captured before the count passed the ring depth");

    a_pct_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> (r_out_pct <= FULL_PERCENT))
        else $error("altitude percentage above full height");

endmodule

/* sv/cala_ctrl.sv */
// cala_ctrl: request sequencer and result handshake of the altitude averager.
// Depends on cala_pkg; drives the datapath through t_cmd, reads t_status.
module cala_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_func,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cala_pkg::t_cmd    o_cmd,
    input  cala_pkg::t_status i_status
);

    import cala_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_SAMPLE    = 8'b0000_0010,
        S_TICK      = 8'b0000_0100,
        S_MEAN_WAIT = 8'b0000_1000,
        S_PCT       = 8'b0001_0000,
        S_PCT_WAIT  = 8'b0010_0000,
        S_RECAL     = 8'b0100_0000,
        S_DONE      = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    case (i_func)
                        FUNC_SAMPLE: n_state = S_SAMPLE;
                        FUNC_TICK:   n_state = S_TICK;
                        FUNC_RECAL:  n_state = S_RECAL;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_SAMPLE: begin
                o_cmd.smp_write = 1'b1;
                n_state         = S_DONE;
            end
            S_TICK: begin
                o_cmd.tick_count = 1'b1;
                o_cmd.mean_start = 1'b1;
                n_state          = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                // Product registered last cycle; take the mean
                o_cmd.mean_latch = 1'b1;
                n_state          = S_PCT;
            end
            S_PCT: begin
                if (i_status.change_zero || i_status.range_zero) begin
                    o_cmd.pct_short = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.pct_start = 1'b1;
                    n_state         = S_PCT_WAIT;
                end
            end
            S_PCT_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.pct_latch = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_RECAL: begin
                o_cmd.recal = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register loaded while a result is still pending");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("second request accepted while one is in work");

    a_mean_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mean_start |=> (r_state == S_MEAN_WAIT))
        else $error("mean product registered without moving on to take it");

endmodule

/* sv/calibrated_altitude_averager_core.sv */
// calibrated_altitude_averager_core: top level of the altitude averager.
// Depends on cala_pkg, cala_ctrl, cala_datapath (with cala_div).
//
// Usage:
//   Requests enter on i_in_valid/o_in_ready with i_func and i_sample. A sample
//   request writes i_sample into the RING_DEPTH-entry ring and updates the
//   running sum. A tick request counts one conversion while uncalibrated, forms
//   the rounded mean of the ring and the altitude percentage against the ground
//   reference. A recalibrate request clears the flag and the count. Every
//   request yields exactly one result on o_out_valid/i_out_ready.
//   Throughput: one request at a time. A sample or recalibrate request goes
//   through a single work state to its result; a tick waits on the
//   bit-serial divider that forms the percentage, and the rounded mean comes
//   from a registered reciprocal multiply. A tick whose percentage needs no
//   division skips the divider. The next request is taken the cycle after
//   the result loads.
//   Reset (i_rst_n low, synchronous) clears the ring, the sum, the reference
//   and the calibration state; the height span returns to 1241.
//   When the receiver stalls, the result register holds its value; the next
//   request is still accepted and worked, and waits only to load its result.
module calibrated_altitude_averager_core #(
    parameter int RING_DEPTH  = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_func,
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [cala_pkg::PCT_W-1:0]    o_altitude_percent,
    output logic [cala_pkg::MEAN_W-1:0]   o_mean_level,
    output logic                          o_calibrated,
    // configuration port, height span register at byte address 0
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    import cala_pkg::*;

    logic [RANGE_W-1:0] r_height_span;
    t_cmd               w_cmd;
    t_status            w_status;
    logic               w_cfg_write;

    // No wait states on the register port
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_SPAN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height_span <= RANGE_RESET;
        end else if (w_cfg_write) begin
            r_height_span <= pwdata[RANGE_W-1:0];
        end
    end

    // Read back the span; addresses beyond the register read as zero
    assign prdata = (paddr[2] == REG_SPAN) ? 32'(r_height_span) : '0;

    cala_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    cala_datapath #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_sample           (i_sample),
        .i_height_span      (r_height_span),
        .o_altitude_percent (o_altitude_percent),
        .o_mean_level       (o_mean_level),
        .o_calibrated       (o_calibrated)
    );

endmodule
